@@ hw/rtl/elf_pkg.sv @@
// Shared types, constants and the flash pattern table for the error LED flasher.
`timescale 1ns / 1ps
`default_nettype none

package elf_pkg;

    localparam int LED_COUNT        = 4;
    localparam int CMD_W            = 2;
    localparam int ERR_ID_W         = 4;
    localparam int TIME_W           = 32;
    localparam int DEF_NUM_ERRORS   = 12;
    localparam int DEF_FLASH_STEPS  = 8;
    localparam int TABLE_ROWS       = 12;
    localparam int TABLE_COLS       = 8;
    localparam int TABLE_COL_W      = 3;

    localparam logic [TIME_W-1:0]   INTERVAL_RESET  = 32'd250000;
    localparam logic [ERR_ID_W-1:0] ALL_STUCK_INDEX = 4'd4;
    localparam logic [ERR_ID_W:0]   ALL_STUCK_SKIP  = 5'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2
    } elf_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ERR_ID_W-1:0] error_id;
        logic [TIME_W-1:0]   now_us;
    } elf_item_t;

    typedef struct packed {
        logic      valid;
        elf_item_t item;
    } elf_stage_t;

    localparam logic [LED_COUNT-1:0] PATTERNS [TABLE_ROWS][TABLE_COLS] = '{
        '{4'h8, 4'h4, 4'h2, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h8, 4'h4, 4'h1, 4'h2, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h8, 4'h2, 4'h4, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h8, 4'h2, 4'h1, 4'h4, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h8, 4'h0, 4'hE, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h8, 4'h0, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h8, 4'h0, 4'h4, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h8, 4'h0, 4'h2, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h2, 4'h0, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h2, 4'h0, 4'h4, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h2, 4'h0, 4'h2, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h4, 4'h2, 4'h0, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0}
    };

    // rows past the defined codes are dark
    function automatic logic [LED_COUNT-1:0] pattern_at(
        input logic [ERR_ID_W-1:0]    row,
        input logic [TABLE_COL_W-1:0] col
    );
        logic [LED_COUNT-1:0] val;
        val = '0;
        if (row < ERR_ID_W'(TABLE_ROWS))
        begin
            val = PATTERNS[row][col];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/elf_item_if.sv @@
// Valid/ready channel carrying one command item.
`timescale 1ns / 1ps
`default_nettype none

interface elf_item_if
    import elf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ERR_ID_W-1:0] error_id;
    logic [TIME_W-1:0]   now_us;

    modport source (output valid, output cmd, output error_id, output now_us, input ready);
    modport sink   (input valid, input cmd, input error_id, input now_us, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/elf_result_if.sv @@
// Valid/ready channel carrying one LED status result.
`timescale 1ns / 1ps
`default_nettype none

interface elf_result_if
    import elf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [LED_COUNT-1:0] leds;
    logic                 leds_written;
    logic                 busy_showing;
    logic [ERR_ID_W-1:0]  current_error;

    modport source (output valid, output leds, output leds_written, output busy_showing,
                    output current_error, input ready);
    modport sink   (input valid, input leds, input leds_written, input busy_showing,
                    input current_error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/elf_in_stage.sv @@
// Input register stage: captures one command item per transfer.
`timescale 1ns / 1ps
`default_nettype none

module elf_in_stage
    import elf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    elf_item_if.sink    item,
    input  wire logic   advance,
    output elf_stage_t  stage
);

    logic      valid_reg;
    logic      valid_next;
    elf_item_t item_reg;
    logic      take;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.cmd      <= item.cmd;
            item_reg.error_id <= item.error_id;
            item_reg.now_us   <= item.now_us;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/elf_core.sv @@
// Flasher state, pending flags, interval register and result register.
`timescale 1ns / 1ps
`default_nettype none

module elf_core
    import elf_pkg::*;
#(
    parameter int NUM_ERRORS  = DEF_NUM_ERRORS,
    parameter int FLASH_STEPS = DEF_FLASH_STEPS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire elf_stage_t          stage,
    output logic                     advance,
    input  wire logic                cfg_wr_en,
    input  wire logic [TIME_W-1:0]   cfg_wr_data,
    elf_result_if.source             result
);

    localparam int STEP_W = $clog2(FLASH_STEPS + 1);
    localparam logic [ERR_ID_W:0] NUM_WIDE = (ERR_ID_W + 1)'(NUM_ERRORS);

    logic [TIME_W-1:0]     interval_reg;
    logic [NUM_ERRORS-1:0] pending_reg, pending_next;
    logic                  showing_reg, showing_next;
    logic [ERR_ID_W-1:0]   ptr_reg, ptr_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [LED_COUNT-1:0]  led_reg, led_next;
    logic                  written_reg, written_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  consume;
    logic [TIME_W-1:0]     elapsed;
    logic [STEP_W-1:0]     step_inc;
    logic [ERR_ID_W:0]     ptr_sum;
    logic [ERR_ID_W:0]     ptr_wrapped;
    logic [ERR_ID_W-1:0]   ptr_step;
    logic                  flag_set;

    assign advance = !out_valid_reg || result.ready;
    assign consume = stage.valid && advance;

    assign elapsed  = stage.item.now_us - start_reg;
    assign step_inc = step_reg + STEP_W'(1);

    // after the all-stuck code the single-encoder codes are passed over
    assign ptr_sum     = {1'b0, ptr_reg} +
                         ((ptr_reg == ALL_STUCK_INDEX) ? ALL_STUCK_SKIP : (ERR_ID_W + 1)'(1));
    assign ptr_wrapped = (ptr_sum >= NUM_WIDE) ? ptr_sum - NUM_WIDE : ptr_sum;
    assign ptr_step    = (ptr_reg == ERR_ID_W'(NUM_ERRORS - 1)) ? '0 : ptr_reg + ERR_ID_W'(1);
    assign flag_set    = ({1'b0, ptr_reg} < NUM_WIDE) ? pending_reg[ptr_reg] : 1'b0;

    always_comb
    begin
        pending_next   = pending_reg;
        showing_next   = showing_reg;
        ptr_next       = ptr_reg;
        step_next      = step_reg;
        start_next     = start_reg;
        led_next       = led_reg;
        written_next   = 1'b0;
        out_valid_next = out_valid_reg;

        if (consume)
        begin
            out_valid_next = 1'b1;
            case (stage.item.cmd)
                CMD_SET, CMD_CLEAR:
                begin
                    if ({1'b0, stage.item.error_id} < NUM_WIDE)
                    begin
                        pending_next[stage.item.error_id] = (stage.item.cmd == CMD_SET);
                    end
                end
                CMD_TICK:
                begin
                    if (showing_reg)
                    begin
                        if (elapsed >= interval_reg)
                        begin
                            start_next = stage.item.now_us;
                            step_next  = step_inc;
                            if (step_inc < STEP_W'(FLASH_STEPS))
                            begin
                                led_next     = pattern_at(ptr_reg, TABLE_COL_W'(step_inc));
                                written_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next     = ptr_wrapped[ERR_ID_W-1:0];
                                showing_next = 1'b0;
                            end
                        end
                    end
                    else if (flag_set)
                    begin
                        showing_next = 1'b1;
                        step_next    = '0;
                        start_next   = stage.item.now_us;
                        led_next     = pattern_at(ptr_reg, '0);
                        written_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_step;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RESET;
            pending_reg   <= '0;
            showing_reg   <= 1'b0;
            ptr_reg       <= '0;
            step_reg      <= '0;
            start_reg     <= '0;
            led_reg       <= '0;
            written_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
            pending_reg   <= pending_next;
            showing_reg   <= showing_next;
            ptr_reg       <= ptr_next;
            step_reg      <= step_next;
            start_reg     <= start_next;
            led_reg       <= led_next;
            if (consume)
            begin
                written_reg <= written_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // state only moves on a transfer into the result register, so it mirrors the result
    assign result.valid         = out_valid_reg;
    assign result.leds          = led_reg;
    assign result.leds_written  = written_reg;
    assign result.busy_showing  = showing_reg;
    assign result.current_error = ptr_reg;

endmodule

`default_nettype wire

@@ hw/rtl/error_code_led_flasher_unit.sv @@
// Top level of the error code LED flasher.
`timescale 1ns / 1ps
`default_nettype none

// Error code LED flasher. Takes command items on the item channel (service tick,
// set flag, clear flag) and returns exactly one result per item on the result
// channel: each item passes through the input register, then the state update that
// loads the result register. Throughput is one item per cycle while the result side
// is not stalled. The flash interval register is to be written through cfg_wr_en and
// cfg_wr_data by the user only while no items are in flight; the block itself does
// not enforce this. The register resets to 250000 microseconds.
module error_code_led_flasher_unit
    import elf_pkg::*;
#(
    parameter int NUM_ERRORS  = DEF_NUM_ERRORS,
    parameter int FLASH_STEPS = DEF_FLASH_STEPS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    elf_item_if.sink               item,
    elf_result_if.source           result,
    input  wire logic              cfg_wr_en,
    input  wire logic [TIME_W-1:0] cfg_wr_data
);

    elf_stage_t stage;
    logic       advance;

    elf_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    elf_core #(
        .NUM_ERRORS  (NUM_ERRORS),
        .FLASH_STEPS (FLASH_STEPS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .advance     (advance),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    a_written_while_showing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.leds_written) |-> result.busy_showing
    ) else $error("LED write reported outside a flash sequence");

    a_pointer_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> ({1'b0, result.current_error} < (ERR_ID_W + 1)'(NUM_ERRORS))
    ) else $error("error pointer beyond the number of codes");

    a_transfer_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> stage.valid
    ) else $error("accepted item lost from the input register");

    a_stage_moves_to_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (stage.valid && advance) |=> result.valid
    ) else $error("item left the input register without a result");

endmodule

`default_nettype wire
